>>> design/hgs_pkg.sv
// Shared types, sizes and the decay table for the heavy guardian sketch.
// Used by hgs_divz, heavy_guardian_sketch and the testbench; depends on nothing.
package hgs_pkg;

    localparam int BUCKETS          = 1024;
    localparam int SLOTS_PER_BUCKET = 8;
    localparam int DECAY_BASE_X1000 = 1080;

    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int FP_W   = 16;
    localparam int CNT_W  = 32;
    localparam int RND_W  = 31;
    localparam int REQ_W  = 2;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EST    = 2'd1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Decay table: two halves of 256 entries, counts from 512 up read the last entry
    localparam int ROM_HALF  = 256;
    localparam int ROM_IDX_W = 9;
    localparam int FRAC_BITS = 20;

    typedef logic [ROM_HALF-1:0][CNT_W-1:0] rom_half_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [FP_W-1:0]  fp;
    } slot_t;

    typedef slot_t [SLOTS_PER_BUCKET-1:0] row_t;

    typedef struct packed {
        logic done;
        logic zero;
    } div_status_t;

    // Fixed-point powers of the decay base, floored at every step
    function automatic rom_half_t build_rom(input int start);
        rom_half_t   r;
        logic [63:0] p;
        logic [63:0] v;
        r = '0;
        p = 64'd1 << FRAC_BITS;
        for (int c = 0; c < start + ROM_HALF; c++)
        begin
            v = p >> FRAC_BITS;
            if (v >= (64'd1 << 31))
                v = 64'd1 << 31;
            if (v < 64'd1)
                v = 64'd1;
            if (c >= start)
                r[c - start] = v[CNT_W-1:0];
            p = p * DECAY_BASE_X1000 / 1000;
            if (p > (64'd1 << 51))
                p = 64'd1 << 51;
        end
        return r;
    endfunction

    localparam rom_half_t ROM_LO = build_rom(0);
    localparam rom_half_t ROM_HI = build_rom(ROM_HALF);

endpackage

>>> design/hgs_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module hgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read on one port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

>>> design/hgs_divz.sv
// Bit-serial restoring divider that reports whether the remainder is zero.
// Depends on hgs_pkg.
module hgs_divz import hgs_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output div_status_t      status
);

    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [RND_W-1:0] quo_reg;
    logic [CNT_W-1:0] div_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    div_status_t      status_reg;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;

    // One quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[RND_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
            rem_next = diff[CNT_W-1:0];
        else
            rem_next = trial[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            status_reg <= '0;
        end
        else
        begin
            status_reg <= '0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(RND_W - 1);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                div_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[RND_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg        <= 1'b0;
                    status_reg.done <= 1'b1;
                    status_reg.zero <= (rem_next == '0);
                end
            end
        end
    end

    assign status = status_reg;

endmodule

>>> design/heavy_guardian_sketch.sv
// Heavy guardian frequency sketch: one bucket row per item, read, modified, written back.
// Each item is loaded, evaluated, put through the serial modulo when the decay test runs, and
// written back; the modulo is skipped for estimate requests and for matching fingerprints.
// A new item is taken only once the last one is written back and its result beat is registered.
// After reset a clearing pass zeroes all 1024 rows, one a cycle, before s_tready rises.
// Depends on hgs_pkg, hgs_ram and hgs_divz.
module heavy_guardian_sketch import hgs_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // bucket_index[9:0], fingerprint[25:10], random_value[56:26]
    input  logic [REQ_W-1:0] s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [CNT_W-1:0] m_tdata,   // estimate[31:0]
    output logic [0:0]       m_tuser    // matched[0]
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [BKT_W-1:0]  clr_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [FP_W-1:0]   fp_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [REQ_W-1:0]  req_reg;
    row_t              row_reg;
    logic [CNT_W-1:0]  ovf_reg;
    logic [SLOT_W-1:0] sel_reg;
    logic [CNT_W-1:0]  minc_reg;
    logic              m_valid_reg;
    logic [CNT_W-1:0]  m_data_reg;
    logic              m_user_reg;

    logic              accept;
    logic              out_free;
    logic [BKT_W-1:0]  ram_addr;
    logic              ram_we;
    row_t              row_rdata;
    logic [CNT_W-1:0]  ovf_rdata;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [CNT_W-1:0]  minc;
    logic [SLOT_W-1:0] min_idx;
    logic [ROM_IDX_W-1:0] rom_idx;
    logic [CNT_W-1:0]  rom_val;
    logic              div_start;
    div_status_t       div_st;
    logic [CNT_W-1:0]  est;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    // Shared address: clear sweep, incoming beat, or held bucket
    always_comb
    begin
        case (state_reg)
            ST_CLEAR: ram_addr = clr_reg;
            ST_IDLE:  ram_addr = s_tdata[BKT_W-1:0];
            default:  ram_addr = bkt_reg;
        endcase
    end
    assign ram_we = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);

    hgs_ram #(.WIDTH($bits(row_t)), .DEPTH(BUCKETS)) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ((state_reg == ST_CLEAR) ? row_t'('0) : row_reg),
        .rdata (row_rdata)
    );

    hgs_ram #(.WIDTH(CNT_W), .DEPTH(BUCKETS)) u_ovf_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ((state_reg == ST_CLEAR) ? '0 : ovf_reg),
        .rdata (ovf_rdata)
    );

    // Find the first matching slot in the held row
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = SLOTS_PER_BUCKET - 1; k >= 0; k--)
        begin
            if (row_reg[k].fp == fp_reg)
            begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(k);
            end
        end
    end

    // Find the lowest-index slot with the smallest count
    always_comb
    begin
        minc    = row_reg[0].cnt;
        min_idx = '0;
        for (int k = 1; k < SLOTS_PER_BUCKET; k++)
        begin
            if (row_reg[k].cnt < minc)
            begin
                minc    = row_reg[k].cnt;
                min_idx = SLOT_W'(k);
            end
        end
    end

    // Look up the decay divisor, clamping large counts to the last entry
    always_comb
    begin
        if (minc >= CNT_W'(2 * ROM_HALF))
            rom_idx = {ROM_IDX_W{1'b1}};
        else
            rom_idx = minc[ROM_IDX_W-1:0];
        if (rom_idx[ROM_IDX_W-1])
            rom_val = ROM_HI[rom_idx[ROM_IDX_W-2:0]];
        else
            rom_val = ROM_LO[rom_idx[ROM_IDX_W-2:0]];
    end

    assign div_start = (state_reg == ST_EVAL) && (req_reg != REQ_EST) && !hit;

    hgs_divz u_divz (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rnd_reg),
        .divisor  (rom_val),
        .status   (div_st)
    );

    // Form the estimate from the updated row
    always_comb
    begin
        est = hit ? row_reg[hit_idx].cnt : ovf_reg;
        if (est == '0)
            est = CNT_W'(1);
    end

    // Sequence one item
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == BKT_W'(BUCKETS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_EVAL;
            ST_EVAL:  state_next = div_start ? ST_DIV : ST_WRITE;
            ST_DIV:   if (div_st.done) state_next = ST_WRITE;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + BKT_W'(1);
            if (state_reg == ST_WRITE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Hold the item, the row and apply the update
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bkt_reg <= s_tdata[BKT_W-1:0];
            fp_reg  <= s_tdata[25:10];
            rnd_reg <= s_tdata[56:26];
            req_reg <= s_tuser;
        end
        if (state_reg == ST_LOAD)
        begin
            row_reg <= row_rdata;
            ovf_reg <= ovf_rdata;
        end
        if (state_reg == ST_EVAL)
        begin
            sel_reg  <= min_idx;
            minc_reg <= minc;
            if (req_reg != REQ_EST && hit && row_reg[hit_idx].cnt != CNT_MAX)
                row_reg[hit_idx].cnt <= row_reg[hit_idx].cnt + CNT_W'(1);
        end
        if (state_reg == ST_DIV && div_st.done && div_st.zero)
        begin
            if (minc_reg <= CNT_W'(1))
            begin
                row_reg[sel_reg].fp  <= fp_reg;
                row_reg[sel_reg].cnt <= CNT_W'(1);
            end
            else
            begin
                row_reg[sel_reg].cnt <= minc_reg - CNT_W'(1);
                if (ovf_reg != CNT_MAX)
                    ovf_reg <= ovf_reg + CNT_W'(1);
            end
        end
        if (state_reg == ST_WRITE && out_free)
        begin
            m_data_reg <= (req_reg == REQ_UPDATE) ? '0 : est;
            m_user_reg <= (req_reg == REQ_UPDATE) ? 1'b0 : hit;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

`ifndef SYNTHESIS
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("input ready during clearing pass");
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOAD)
        else $error("accepted beat did not start a row load");
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> state_reg == ST_DIV)
        else $error("modulo finished outside its state");
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && out_free) |=> m_tvalid)
        else $error("finished item gave no result beat");
`endif

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for heavy_guardian_sketch: a directed table, then random traffic.
// Predicts each result from a local sketch model; depends on hgs_pkg and the block's RTL.
module tb_top import hgs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT   = 1024;
    localparam int NSLOT  = 8;
    localparam int TAB_D  = 512;
    localparam int RAND_N = 1900;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  req;
        logic [9:0]  bkt;
        logic [15:0] fp;
        logic [30:0] rnd;
    } req_beat_t;

    typedef struct packed {
        logic [31:0] est;
        logic        hit;
    } est_beat_t;

    typedef struct {
        req_beat_t  beat;
        logic       fixed;   // expected value typed into the table
        est_beat_t  want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    heavy_guardian_sketch uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Local copy of the sketch state
    logic [15:0] mdl_fp  [NBKT*NSLOT];
    logic [31:0] mdl_cnt [NBKT*NSLOT];
    logic [31:0] mdl_ovf [NBKT];
    logic [31:0] decay_tab [TAB_D];

    est_beat_t est_queue [$];
    int        errors;
    bit        quiet;      // no idling in the last part
    bit        long_hold;  // receiver holds off for a long stretch
    bit        drive_done;
    longint    cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void build_decay_tab();
        logic [63:0] p;
        logic [63:0] v;
        p = 64'd1 << 20;
        for (int c = 0; c < TAB_D; c++)
        begin
            v = p >> 20;
            if (v >= (64'd1 << 31))
                v = 64'd1 << 31;
            if (v < 64'd1)
                v = 64'd1;
            decay_tab[c] = v[31:0];
            p = p * 64'd1080 / 64'd1000;
            if (p > (64'd1 << 51))
                p = 64'd1 << 51;
        end
    endfunction

    // Update the local sketch and return the expected estimate beat
    function automatic est_beat_t sketch_predict(req_beat_t b);
        est_beat_t   r;
        int unsigned base;
        int unsigned sel;
        logic [31:0] minc;
        logic [31:0] div;
        bit          found;
        base = b.bkt * NSLOT;
        r = '0;
        found = 0;
        if (b.req != REQ_EST)
        begin
            for (int k = 0; k < NSLOT; k++)
                if (!found && mdl_fp[base+k] == b.fp)
                begin
                    found = 1;
                    if (mdl_cnt[base+k] != 32'hFFFF_FFFF)
                        mdl_cnt[base+k]++;
                end
            if (!found)
            begin
                sel = 0;
                minc = mdl_cnt[base];
                for (int k = 1; k < NSLOT; k++)
                    if (mdl_cnt[base+k] < minc)
                    begin
                        minc = mdl_cnt[base+k];
                        sel = k;
                    end
                div = decay_tab[(minc >= TAB_D) ? TAB_D-1 : minc];
                if ({1'b0, b.rnd} % div == 0)
                begin
                    if (minc <= 1)
                    begin
                        mdl_fp[base+sel] = b.fp;
                        mdl_cnt[base+sel] = 1;
                    end
                    else
                    begin
                        mdl_cnt[base+sel] = minc - 1;
                        if (mdl_ovf[b.bkt] != 32'hFFFF_FFFF)
                            mdl_ovf[b.bkt]++;
                    end
                end
            end
        end
        if (b.req != REQ_UPDATE)
        begin
            r.est = mdl_ovf[b.bkt];
            found = 0;
            for (int k = 0; k < NSLOT; k++)
                if (!found && mdl_fp[base+k] == b.fp)
                begin
                    found = 1;
                    r.est = mdl_cnt[base+k];
                    r.hit = 1'b1;
                end
            if (r.est < 1)
                r.est = 1;
        end
        return r;
    endfunction

    function automatic req_beat_t mk(logic [1:0] q, logic [9:0] bk, logic [15:0] f,
                                     logic [30:0] rv);
        req_beat_t b;
        b.req = q;
        b.bkt = bk;
        b.fp  = f;
        b.rnd = rv;
        return b;
    endfunction

    // Offer one beat and hold it until accepted
    task automatic send_beat(req_beat_t b, bit fixed, est_beat_t want);
        est_beat_t p;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.req;
        s_tdata  <= {7'd0, b.rnd, b.fp, b.bkt};
        p = sketch_predict(b);
        if (fixed && p != want)
        begin
            $display("%0t table row disagrees with predictor: table %h predictor %h",
                     $time, want, p);
            errors++;
        end
        est_queue.push_back(p);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    dir_row_t dir_tab [$];

    task automatic add_row(req_beat_t b, bit fixed, logic [31:0] e, logic h);
        dir_row_t r;
        r.beat = b;
        r.fixed = fixed;
        r.want.est = e;
        r.want.hit = h;
        dir_tab.push_back(r);
    endtask

    // Stimulus
    initial
    begin
        req_beat_t b;
        int unsigned hot_bkt;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        rst_n    = 1'b0;
        errors = 0;
        quiet = 0;
        drive_done = 0;
        build_decay_tab();
        for (int i = 0; i < NBKT*NSLOT; i++)
        begin
            mdl_fp[i] = '0;
            mdl_cnt[i] = '0;
        end
        for (int i = 0; i < NBKT; i++)
            mdl_ovf[i] = '0;

        // Fresh table: estimates, updates and combined requests; empty slots match fingerprint zero
        add_row(mk(REQ_EST, 10'd0, 16'd5, 31'd0), 1'b1, 32'd1, 1'b0);
        add_row(mk(REQ_EST, 10'd1023, 16'd0, 31'd0), 1'b1, 32'd1, 1'b1);
        add_row(mk(REQ_UPDATE, 10'd1023, 16'hFFFF, 31'h7FFF_FFFF), 1'b1, 32'd0, 1'b0);
        add_row(mk(2'd2, 10'd1023, 16'hFFFF, 31'd0), 1'b1, 32'd2, 1'b1);
        add_row(mk(2'd3, 10'd1023, 16'hFFFF, 31'd0), 1'b1, 32'd3, 1'b1);
        add_row(mk(2'd2, 10'd0, 16'd0, 31'd0), 1'b1, 32'd1, 1'b1);
        add_row(mk(2'd2, 10'd0, 16'h1234, 31'd0), 1'b0, 32'd0, 1'b0);
        add_row(mk(2'd2, 10'd0, 16'h8000, 31'h7FFF_FFFF), 1'b0, 32'd0, 1'b0);
        add_row(mk(2'd3, 10'd512, 16'h00AA, 31'h5555_5555), 1'b0, 32'd0, 1'b0);
        add_row(mk(REQ_EST, 10'd512, 16'h00AA, 31'h2AAA_AAAA), 1'b0, 32'd0, 1'b0);
        // Fill bucket 7 then force decay that replaces the smallest slot
        for (int i = 1; i <= 8; i++)
            add_row(mk(REQ_UPDATE, 10'd7, 16'(i), 31'd0), 1'b0, 32'd0, 1'b0);
        add_row(mk(2'd2, 10'd7, 16'd1, 31'd0), 1'b0, 32'd0, 1'b0);
        for (int i = 0; i < 4; i++)
            add_row(mk(2'd2, 10'd7, 16'h4000 + 16'(i), 31'd0), 1'b0, 32'd0, 1'b0);
        add_row(mk(REQ_EST, 10'd7, 16'h7777, 31'd0), 1'b0, 32'd0, 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
            send_beat(dir_tab[i].beat, dir_tab[i].fixed, dir_tab[i].want);

        // Random part: mostly a few hot buckets and fingerprints, with full-range noise
        for (int n = 0; n < RAND_N; n++)
        begin
            if (n > RAND_N - 150)
                quiet = 1;
            b.req = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
            begin
                b.bkt = 10'($urandom);
                b.fp  = 16'($urandom);
            end
            else
            begin
                hot_bkt = $urandom_range(0, 5);
                b.bkt = (hot_bkt == 5) ? 10'h3FF : 10'(hot_bkt * 97);
                b.fp  = 16'($urandom_range(0, 11))
                        ^ (($urandom_range(0, 7) == 0) ? 16'hFFF0 : 16'h0000);
            end
            case ($urandom_range(0, 3))
                0: b.rnd = 31'd0;
                1: b.rnd = 31'($urandom_range(0, 3)) * 31'(decay_tab[$urandom_range(0, 12)]);
                default: b.rnd = 31'($urandom);
            endcase
            send_beat(b, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        drive_done = 1;
    end

    // Receiver readiness, with one long hold-off while traffic continues
    initial
    begin
        int gap;
        m_tready = 1'b0;
        long_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold && est_queue.size() > 0 && cycles > 3000 && cycles < 3100)
            begin
                long_hold = 1;
                m_tready <= 1'b0;
                repeat (600) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        est_beat_t exp_b;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (est_queue.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual est %0d matched %0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                exp_b = est_queue.pop_front();
                if (m_tdata !== exp_b.est)
                begin
                    $display("%0t estimate mismatch: expected %0d actual %0d",
                             $time, exp_b.est, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== exp_b.hit)
                begin
                    $display("%0t matched mismatch: expected %0d actual %0d",
                             $time, exp_b.hit, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Cycle limit and end of run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
            if (drive_done && est_queue.size() == 0)
            begin
                repeat (100) @(posedge clk);
                if (errors == 0 && est_queue.size() == 0)
                    $display("tb_top: PASS");
                else
                    $display("tb_top: FAIL");
                $finish;
            end
        end
    end
endmodule
